FILE: rtl/core/histogram_mode_finder_unit_assert.svh
// ----------------------------------------------------------------------------
// Histogram mode finder assertion macros
// Shared macros for the concurrent checks of the histogram mode finder.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_MODE_FINDER_UNIT_ASSERT_SVH
`define HISTOGRAM_MODE_FINDER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HMF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram mode finder check failed");

// The consequent must hold in the cycle after the antecedent.
`define HMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram mode finder check failed");

`endif

FILE: rtl/core/hmf_pkg.sv
// ----------------------------------------------------------------------------
// Histogram mode finder package
// Types, sizes and helper functions shared by the histogram mode finder.
// ----------------------------------------------------------------------------
package hmf_pkg;

   localparam int VALUE_BITS = 15;
   localparam int COUNT_BITS = 16;
   localparam int NUM_BINS = 1 << VALUE_BITS;
   localparam int SAMPLE_BITS = 15;
   localparam int OUT_COUNT_BITS = 16;
   localparam int WIDE_BITS = 32;
   localparam logic [WIDE_BITS-1:0] OUT_COUNT_MAX = WIDE_BITS'((1 << OUT_COUNT_BITS) - 1);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mode_value;
      logic [OUT_COUNT_BITS-1:0]     mode_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_COUNT,
      ST_FLUSH,
      ST_SCAN,
      ST_TAIL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  busy;
      logic                  sweep_read;
      logic                  sweep_clear;
      logic                  best_init;
      logic                  report;
      logic [VALUE_BITS-1:0] sweep_addr;
   } ctrl_type;

   // Biasing by half the bin range only flips the top bit of the index.
   function automatic logic [VALUE_BITS-1:0] bin_index(
      input logic signed [SAMPLE_BITS-1:0] sample);
      logic signed [WIDE_BITS-1:0] ext;
      logic [VALUE_BITS-1:0]       idx;
      ext = WIDE_BITS'(sample);
      idx = ext[VALUE_BITS-1:0];
      idx[VALUE_BITS-1] = ~idx[VALUE_BITS-1];
      return idx;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] bin_value(
      input logic [VALUE_BITS-1:0] idx);
      logic [VALUE_BITS-1:0]       val;
      logic signed [WIDE_BITS-1:0] ext;
      val = idx;
      val[VALUE_BITS-1] = ~val[VALUE_BITS-1];
      ext = WIDE_BITS'($signed(val));
      return ext[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic [OUT_COUNT_BITS-1:0] out_count(
      input logic [COUNT_BITS-1:0] count);
      logic [WIDE_BITS-1:0] ext;
      ext = WIDE_BITS'(count);
      if (ext > OUT_COUNT_MAX) begin
         return '1;
      end
      return ext[OUT_COUNT_BITS-1:0];
   endfunction

endpackage

FILE: rtl/core/hmf_ram.sv
// ----------------------------------------------------------------------------
// Histogram mode finder RAM
// Generic single-write, single-read RAM with a registered, read-first output.
// ----------------------------------------------------------------------------
module hmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/hmf_ctrl.sv
// ----------------------------------------------------------------------------
// Histogram mode finder control
// Sequences the clearing pass, sample counting, bin scan and result report.
// ----------------------------------------------------------------------------
module hmf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept_last,
   output hmf_pkg::ctrl_type ctrl
);

   import hmf_pkg::*;

   state_type             state_ff;
   state_type             state_in;
   logic [VALUE_BITS-1:0] addr_ff;
   logic [VALUE_BITS-1:0] addr_in;
   logic                  addr_end;

   assign addr_end = &addr_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (addr_end) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (accept_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_SCAN;
         ST_SCAN: begin
            if (addr_end) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: state_in = ST_DONE;
         ST_DONE: state_in = ST_COUNT;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.busy = (state_ff != ST_COUNT);
      ctrl.sweep_addr = addr_ff;
      case (state_ff)
         ST_CLEAR: ctrl.sweep_clear = 1'b1;
         ST_FLUSH: ctrl.best_init = 1'b1;
         ST_SCAN:  ctrl.sweep_read = 1'b1;
         ST_DONE:  ctrl.report = 1'b1;
         default:  ctrl.sweep_read = 1'b0;
      endcase
   end

   assign addr_in = (ctrl.sweep_clear || ctrl.sweep_read) ? addr_ff + 1'b1 : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
      end
   end

endmodule

FILE: rtl/core/histogram_mode_finder_unit.sv
// ----------------------------------------------------------------------------
// Histogram mode finder unit
// Counts samples in a bin RAM and reports the most frequent value per set.
// ----------------------------------------------------------------------------
// Throughput: one sample word per cycle while counting; the bin RAM does one
// read-modify-write per cycle with forwarding of the previous write.
// Report: after the last sample is accepted, the control passes a flush state, a
// scan of one bin per cycle through the RAM port and a tail state, then strobes.
// Reset: busy stays high after reset while a clearing pass zeroes every bin.
// Results cannot be stalled; the strobe lasts one cycle.
module histogram_mode_finder_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hmf_pkg::req_type req_word,
   output logic             rsp_strobe,
   output hmf_pkg::rsp_type rsp_word
);

   import hmf_pkg::*;

   ctrl_type              ctrl;
   logic                  accept;
   logic                  wr_en;
   logic [VALUE_BITS-1:0] wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [VALUE_BITS-1:0] rd_addr;
   logic [COUNT_BITS-1:0] rd_data;
   logic [COUNT_BITS-1:0] old_count;
   logic [COUNT_BITS-1:0] new_count;

   logic                  s1_vld_ff;
   logic [VALUE_BITS-1:0] s1_idx_ff;
   logic                  fwd_vld_ff;
   logic [VALUE_BITS-1:0] fwd_idx_ff;
   logic [COUNT_BITS-1:0] fwd_cnt_ff;
   logic                  scan_vld_ff;
   logic [VALUE_BITS-1:0] scan_idx_ff;
   logic [VALUE_BITS-1:0] best_idx_ff;
   logic [VALUE_BITS-1:0] best_idx_in;
   logic [COUNT_BITS-1:0] best_cnt_ff;
   logic [COUNT_BITS-1:0] best_cnt_in;

   assign accept = start && !busy;
   assign busy = ctrl.busy;

   hmf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept_last (accept && req_word.last_sample),
      .ctrl        (ctrl)
   );

   hmf_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = accept ? bin_index(req_word.sample_value) : ctrl.sweep_addr;

   assign old_count = (fwd_vld_ff && fwd_idx_ff == s1_idx_ff) ? fwd_cnt_ff : rd_data;
   assign new_count = (&old_count) ? old_count : old_count + 1'b1;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = s1_idx_ff;
      wr_data = '0;
      if (s1_vld_ff) begin
         wr_en = 1'b1;
         wr_data = new_count;
      end else if (ctrl.sweep_clear) begin
         wr_en = 1'b1;
         wr_addr = ctrl.sweep_addr;
      end else if (scan_vld_ff) begin
         wr_en = 1'b1;
         wr_addr = scan_idx_ff;
      end
   end

   always_comb begin
      best_idx_in = best_idx_ff;
      best_cnt_in = best_cnt_ff;
      if (ctrl.best_init) begin
         best_idx_in = '0;
         best_cnt_in = '0;
      end else if (scan_vld_ff && rd_data > best_cnt_ff) begin
         best_idx_in = scan_idx_ff;
         best_cnt_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         fwd_vld_ff <= 1'b0;
         scan_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         fwd_vld_ff <= s1_vld_ff;
         scan_vld_ff <= ctrl.sweep_read;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= rd_addr;
      fwd_idx_ff <= s1_idx_ff;
      fwd_cnt_ff <= new_count;
      scan_idx_ff <= ctrl.sweep_addr;
      best_idx_ff <= best_idx_in;
      best_cnt_ff <= best_cnt_in;
   end

   assign rsp_strobe = ctrl.report;
   assign rsp_word.mode_value = bin_value(best_idx_ff);
   assign rsp_word.mode_count = out_count(best_cnt_ff);

endmodule

FILE: rtl/core/hmf_checker.sv
// ----------------------------------------------------------------------------
// Histogram mode finder checker
// Port-level checks of the handshake and report sequencing, bound to the top.
// ----------------------------------------------------------------------------
`include "histogram_mode_finder_unit_assert.svh"

module hmf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input hmf_pkg::req_type req_word,
   input logic             rsp_strobe
);

   import hmf_pkg::*;

   `HMF_ASSERT_NEXT(a_reset_busy, clock, 1'b0, reset, busy)
   `HMF_ASSERT_NOW(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `HMF_ASSERT_NEXT(a_last_busy, clock, reset, start && !busy && req_word.last_sample, busy)
   `HMF_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

endmodule

bind histogram_mode_finder_unit hmf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram mode finder unit testbench
// Sends data sets of signed sample words, checks each reported mode value and
// count against a histogram kept in the bench, and covers ties and extreme
// values. The sender idles at random in several phases.
// ----------------------------------------------------------------------------
module tb_top;
   import hmf_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int CYCLE_LIMIT = 200_000_000;
   localparam int DRAIN_CYCLES = NUM_BINS + 64;
   localparam int VALUE_BIAS = 1 << (VALUE_BITS - 1);
   localparam int PHASE_ITEMS = 330;

   typedef struct {
      req_type word;
      bit      drain_first;
   } sample_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   sample_item_type       sample_fifo[$];
   rsp_type               expected_modes[$];
   logic [COUNT_BITS-1:0] bin_tally[NUM_BINS];
   int                    error_count = 0;
   int                    cycle_count = 0;
   int                    sender_idle_pct = 0;

   histogram_mode_finder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #HALF_PERIOD clock = ~clock;

   function void count_sample(input req_type word);
      logic [VALUE_BITS-1:0] idx;
      logic [COUNT_BITS-1:0] top_count;
      int                    top_value;
      rsp_type               mode;
      idx = VALUE_BITS'(int'(word.sample_value) + VALUE_BIAS);
      if (bin_tally[idx] != '1) begin
         bin_tally[idx] = bin_tally[idx] + 1'b1;
      end
      if (word.last_sample) begin
         top_count = '0;
         top_value = 0;
         for (int i = 0; i < NUM_BINS; i++) begin
            if (bin_tally[i] > top_count) begin
               top_count = bin_tally[i];
               top_value = i - VALUE_BIAS;
            end
         end
         mode.mode_value = SAMPLE_BITS'(top_value);
         if (64'(top_count) > 64'((1 << OUT_COUNT_BITS) - 1)) begin
            mode.mode_count = '1;
         end else begin
            mode.mode_count = OUT_COUNT_BITS'(top_count);
         end
         expected_modes = {expected_modes, mode};
         foreach (bin_tally[j]) begin
            bin_tally[j] = '0;
         end
      end
   endfunction

   function int random_sample();
      return int'($signed(SAMPLE_BITS'($urandom)));
   endfunction

   task report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   task add_sample(input int value, input bit last, input bit drain);
      sample_item_type item;
      item.word.sample_value = SAMPLE_BITS'(value);
      item.word.last_sample = last;
      item.drain_first = drain;
      sample_fifo = {sample_fifo, item};
   endtask

   task automatic add_random_set(output int length);
      int pool[6];
      int pool_size;
      bit scatter;
      int value;
      length = $urandom_range(1, 64);
      pool_size = $urandom_range(1, 6);
      scatter = ($urandom_range(4) == 0);
      foreach (pool[k]) begin
         case ($urandom_range(5))
            0: pool[k] = -(1 << (SAMPLE_BITS - 1));
            1: pool[k] = (1 << (SAMPLE_BITS - 1)) - 1;
            2: pool[k] = int'($urandom_range(8)) - 4;
            default: pool[k] = random_sample();
         endcase
      end
      for (int i = 0; i < length; i++) begin
         value = scatter ? random_sample() : pool[$urandom_range(pool_size - 1)];
         add_sample(value, i == length - 1, i == 0 && $urandom_range(3) == 0);
      end
   endtask

   task wait_idle();
      do begin
         @(posedge clock);
      end while (sample_fifo.size() != 0 || start || expected_modes.size() != 0);
   endtask

   always @(posedge clock) begin
      bit take;
      bit go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         take = start && !busy;
         if (take) begin
            count_sample(req_word);
         end
         if (take || !start) begin
            go = sample_fifo.size() != 0 && $urandom_range(99) >= sender_idle_pct;
            if (go && sample_fifo[0].drain_first && expected_modes.size() != 0) begin
               go = 1'b0;
            end
            if (go) begin
               req_word <= sample_fifo[0].word;
               void'(sample_fifo.pop_front());
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_modes.size() == 0) begin
            report_mismatch("unexpected result word, mode value", rsp_word.mode_value, 0);
         end else begin
            want = expected_modes.pop_front();
            if (rsp_word.mode_value !== want.mode_value) begin
               report_mismatch("mode value", rsp_word.mode_value, want.mode_value);
            end
            if (rsp_word.mode_count !== want.mode_count) begin
               report_mismatch("mode count", rsp_word.mode_count, want.mode_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("histogram_mode_finder_unit: mismatch");
         $finish;
      end
   end

   initial begin
      int phase_pct[3];
      int added;
      int length;
      phase_pct = '{35, 72, 0};
      foreach (bin_tally[j]) begin
         bin_tally[j] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 35;
      add_sample(-16384, 1'b1, 1'b0);
      add_sample(16383, 1'b1, 1'b0);
      add_sample(5, 1'b0, 1'b0);
      add_sample(-3, 1'b0, 1'b0);
      add_sample(5, 1'b0, 1'b0);
      add_sample(-3, 1'b0, 1'b0);
      add_sample(0, 1'b1, 1'b0);
      add_sample(16383, 1'b0, 1'b1);
      add_sample(16383, 1'b0, 1'b0);
      add_sample(-16384, 1'b1, 1'b0);
      add_sample(7, 1'b0, 1'b0);
      add_sample(-7, 1'b0, 1'b0);
      add_sample(100, 1'b0, 1'b0);
      add_sample(-16384, 1'b0, 1'b0);
      add_sample(-1, 1'b1, 1'b0);
      add_sample(0, 1'b0, 1'b0);
      add_sample(-1, 1'b0, 1'b0);
      add_sample(0, 1'b0, 1'b0);
      add_sample(-1, 1'b0, 1'b0);
      add_sample(0, 1'b1, 1'b0);
      add_sample(21845, 1'b0, 1'b1);
      add_sample(-10923, 1'b0, 1'b0);
      add_sample(-10923, 1'b1, 1'b0);
      wait_idle();

      foreach (phase_pct[p]) begin
         sender_idle_pct = phase_pct[p];
         added = 0;
         while (added < PHASE_ITEMS) begin
            add_random_set(length);
            added += length;
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("histogram_mode_finder_unit: match");
      end else begin
         $display("histogram_mode_finder_unit: mismatch");
      end
      $finish;
   end

endmodule

FILE: histogram_mode_finder_unit.f
+incdir+rtl/core
rtl/core/hmf_pkg.sv
rtl/core/hmf_ram.sv
rtl/core/hmf_ctrl.sv
rtl/core/histogram_mode_finder_unit.sv
rtl/core/hmf_checker.sv
tb/tb_top.sv
